/* sv/u8mu7_pkg.sv */
// Shared types, constants and the base64 alphabet for the modified UTF-7 encoder.
`timescale 1ns / 1ps
`default_nettype none
package u8mu7_pkg;

  localparam int MaxRes   = 5;
  localparam int ResCntW  = $clog2(MaxRes + 1);
  // result queue depth, a power of two so that the pointers wrap by themselves
  localparam int FifoDepth = 8;
  localparam int PtrW      = $clog2(FifoDepth);
  localparam int CntW      = $clog2(FifoDepth + 1);

  localparam logic [6:0] ChNul    = 7'h00;
  localparam logic [6:0] ChAmp    = 7'h26;
  localparam logic [6:0] ChDash   = 7'h2d;
  localparam logic [6:0] ResetSep = 7'd47;

  localparam logic [4:0] Shift10 = 5'd10;
  localparam logic [4:0] Shift12 = 5'd12;
  localparam logic [4:0] Shift14 = 5'd14;

  typedef struct packed {
    logic [6:0] ch;
    logic       run_last;
    logic       string_end;
    logic       err;
  } res_t;

  typedef res_t [MaxRes-1:0] res_vec_t;

  typedef struct packed {
    logic        in_run;
    logic [5:0]  residue;
    logic [4:0]  shift;
    logic [30:0] acc;
    logic [2:0]  cont;
    logic [2:0]  seq_len;
    logic        err_seen;
  } st_t;

  localparam st_t StClear = '{
    in_run:   1'b0,
    residue:  6'd0,
    shift:    5'd10,
    acc:      31'd0,
    cont:     3'd0,
    seq_len:  3'd0,
    err_seen: 1'b0
  };

  function automatic logic [6:0] b64_char(input logic [5:0] v);
    logic [6:0] r;
    if (v < 6'd26) begin
      r = 7'h41 + {1'b0, v};
    end else if (v < 6'd52) begin
      r = 7'h47 + {1'b0, v};
    end else if (v < 6'd62) begin
      r = {1'b0, v} - 7'd4;
    end else if (v == 6'd62) begin
      r = 7'h2b;
    end else begin
      r = 7'h2c;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* sv/u8mu7_step.sv */
// Combinational step: decode one UTF-8 byte and form up to five result characters.
`timescale 1ns / 1ps
`default_nettype none
module u8mu7_step (
  input  u8mu7_pkg::st_t                      st_i,
  input  logic [7:0]                          byte_i,
  input  logic                                last_i,
  input  logic [6:0]                          sep_i,
  output u8mu7_pkg::st_t                      nxt_o,
  output u8mu7_pkg::res_vec_t                 res_o,
  output logic [u8mu7_pkg::ResCntW-1:0]       cnt_o
);
  import u8mu7_pkg::*;

  function automatic res_t mk(input logic [6:0] c);
    res_t r;
    r = '0;
    r.ch = c;
    return r;
  endfunction

  always_comb begin
    st_t           nx;
    res_vec_t      rv;
    logic [2:0]    n;
    logic          fl;
    logic          enc;
    logic [30:0]   pt;
    logic [30:0]   acc_new;
    logic [30:0]   acc_lead;
    logic [2:0]    len;
    logic          bad;
    logic          ovl;
    logic          run_w;
    logic [5:0]    rsd_w;
    logic [4:0]    sh_w;
    logic [15:0]   ch16;

    nx       = st_i;
    rv       = '0;
    n        = 3'd0;
    fl       = 1'b0;
    enc      = 1'b0;
    pt       = st_i.acc;
    acc_new  = {st_i.acc[24:0], byte_i[5:0]};
    run_w    = st_i.in_run;
    rsd_w    = st_i.residue;
    sh_w     = st_i.shift;
    ch16     = 16'd0;
    bad      = 1'b0;
    acc_lead = 31'd0;
    len      = 3'd0;

    if (byte_i < 8'h80) begin
      acc_lead = {23'd0, byte_i};
    end else if (byte_i < 8'hc2) begin
      bad = 1'b1;
    end else if (byte_i < 8'he0) begin
      acc_lead = {26'd0, byte_i[4:0]};
      len = 3'd1;
    end else if (byte_i < 8'hf0) begin
      acc_lead = {27'd0, byte_i[3:0]};
      len = 3'd2;
    end else if (byte_i < 8'hf8) begin
      acc_lead = {28'd0, byte_i[2:0]};
      len = 3'd3;
    end else if (byte_i < 8'hfc) begin
      acc_lead = {29'd0, byte_i[1:0]};
      len = 3'd4;
    end else if (byte_i < 8'hfe) begin
      acc_lead = {30'd0, byte_i[0]};
      len = 3'd5;
    end else begin
      bad = 1'b1;
    end

    case (st_i.seq_len)
      3'd2: begin
        ovl = (acc_new[30:11] == '0);
      end
      3'd3: begin
        ovl = (acc_new[30:16] == '0);
      end
      3'd4: begin
        ovl = (acc_new[30:21] == '0);
      end
      3'd5: begin
        ovl = (acc_new[30:26] == '0);
      end
      default: begin
        ovl = 1'b0;
      end
    endcase

    if (!st_i.err_seen) begin
      if (st_i.cont == 3'd0) begin
        if (!st_i.in_run && byte_i == {1'b0, sep_i}) begin
          rv[n] = mk(ChAmp);                               n = n + 3'd1;
          rv[n] = mk(b64_char(6'd0));                      n = n + 3'd1;
          rv[n] = mk(b64_char({2'b00, byte_i[7:4]}));      n = n + 3'd1;
          rv[n] = mk(b64_char({byte_i[3:0], 2'b00}));      n = n + 3'd1;
          rv[n] = mk(ChDash);                              n = n + 3'd1;
        end else if (bad || (len != 3'd0 && last_i)) begin
          fl = 1'b1;
        end else begin
          nx.acc     = acc_lead;
          nx.seq_len = len;
          nx.cont    = len;
          enc        = (len == 3'd0);
          pt         = acc_lead;
        end
      end else if (byte_i[7:6] != 2'b10 || (last_i && st_i.cont > 3'd1)) begin
        fl = 1'b1;
      end else begin
        nx.acc  = acc_new;
        nx.cont = st_i.cont - 3'd1;
        if (st_i.cont == 3'd1) begin
          if (ovl) begin
            fl = 1'b1;
          end else begin
            enc = 1'b1;
            pt  = acc_new;
          end
        end
      end

      if (enc) begin
        if (pt < 31'h20 || pt >= 31'h7f) begin
          if (!run_w) begin
            rv[n] = mk(ChAmp); n = n + 3'd1;
            run_w = 1'b1;
            rsd_w = 6'd0;
            sh_w  = Shift10;
          end
          ch16 = (pt > 31'hffff) ? 16'hfffe : pt[15:0];
          case (sh_w)
            Shift14: begin
              rv[n] = mk(b64_char(rsd_w | {4'b0000, ch16[15:14]})); n = n + 3'd1;
              rv[n] = mk(b64_char(ch16[13:8]));                     n = n + 3'd1;
              rv[n] = mk(b64_char(ch16[7:2]));                      n = n + 3'd1;
              rsd_w = {ch16[1:0], 4'b0000};
              sh_w  = Shift12;
            end
            Shift12: begin
              rv[n] = mk(b64_char(rsd_w | {2'b00, ch16[15:12]}));   n = n + 3'd1;
              rv[n] = mk(b64_char(ch16[11:6]));                     n = n + 3'd1;
              rv[n] = mk(b64_char(ch16[5:0]));                      n = n + 3'd1;
              rsd_w = 6'd0;
              sh_w  = Shift10;
            end
            default: begin
              rv[n] = mk(b64_char(rsd_w | ch16[15:10]));            n = n + 3'd1;
              rv[n] = mk(b64_char(ch16[9:4]));                      n = n + 3'd1;
              rsd_w = {ch16[3:0], 2'b00};
              sh_w  = Shift14;
            end
          endcase
        end else begin
          if (run_w) begin
            if (sh_w != Shift10) begin
              rv[n] = mk(b64_char(rsd_w)); n = n + 3'd1;
            end
            rv[n] = mk(ChDash); n = n + 3'd1;
            run_w = 1'b0;
          end
          rv[n] = mk(pt[6:0]); n = n + 3'd1;
          if (pt[6:0] == ChAmp) begin
            rv[n] = mk(ChDash); n = n + 3'd1;
          end
        end
      end

      nx.in_run  = run_w;
      nx.residue = rsd_w;
      nx.shift   = sh_w;

      // flush an open run on the last byte
      if (!fl && last_i) begin
        if (run_w) begin
          if (sh_w != Shift10) begin
            rv[n] = mk(b64_char(rsd_w)); n = n + 3'd1;
          end
          rv[n] = mk(ChDash); n = n + 3'd1;
        end
        nx = StClear;
      end

      if (fl) begin
        rv             = '0;
        rv[0].ch       = ChNul;
        rv[0].run_last   = 1'b1;
        rv[0].string_end = 1'b1;
        rv[0].err        = 1'b1;
        n              = 3'd1;
        nx             = st_i;
        nx.err_seen    = 1'b1;
        if (last_i) begin
          nx = StClear;
        end
      end else if (n != 3'd0) begin
        rv[n - 3'd1].run_last   = 1'b1;
        rv[n - 3'd1].string_end = last_i;
      end
    end else if (last_i) begin
      nx = StClear;
    end

    nxt_o = nx;
    res_o = rv;
    cnt_o = n;
  end

endmodule
`default_nettype wire

/* sv/utf8_to_modified_utf7_encoder.sv */
// Top level of the UTF-8 to IMAP modified UTF-7 encoder with its result queue.
//
// Takes one UTF-8 byte per request and returns the modified UTF-7 characters
// it causes, one per output request. A byte is taken into an input register,
// processed against the string state and the separator register, and its
// zero to five results are written at once into an 8-entry result queue.
// One byte can be accepted every cycle; a byte that causes k results gives
// k output requests, and the input register holds a byte until the queue
// has room for all of its results. A byte passes the input register, then
// the queue. A malformed string gives one result with tuser set and drops
// its remaining bytes up to the one marked tlast.
`timescale 1ns / 1ps
`default_nettype none
module utf8_to_modified_utf7_encoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_wdata_i,      // separator_char
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  input  logic       s_axis_tlast_i,   // last_byte
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [6:0] out_char, [7] run_last
  output logic       m_axis_tlast_o,   // string_end
  output logic       m_axis_tuser_o    // [0] encode_error
);
  import u8mu7_pkg::*;

  logic             in_valid_q;
  logic [7:0]       in_byte_q;
  logic             in_last_q;
  logic [6:0]       sep_q;
  st_t              st_q;
  st_t              st_d;
  res_vec_t         res;
  logic [ResCntW-1:0] res_cnt;
  logic             proc_fire;
  logic             s_fire;
  logic             pop;
  res_t             mem [FifoDepth];
  res_t             head;
  logic [PtrW-1:0]  wr_ptr_q;
  logic [PtrW-1:0]  wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q;
  logic [PtrW-1:0]  rd_ptr_d;
  logic [CntW-1:0]  count_q;
  logic [CntW-1:0]  count_d;

  u8mu7_step u_step (
    .st_i   (st_q),
    .byte_i (in_byte_q),
    .last_i (in_last_q),
    .sep_i  (sep_q),
    .nxt_o  (st_d),
    .res_o  (res),
    .cnt_o  (res_cnt)
  );

  assign proc_fire = in_valid_q &&
                     ((CntW'(res_cnt) + count_q) <= CntW'(FifoDepth));
  assign s_axis_tready_o = !in_valid_q || proc_fire;
  assign s_fire = s_axis_tvalid_i && s_axis_tready_o;
  assign pop = m_axis_tvalid_o && m_axis_tready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    count_d  = count_q;
    rd_ptr_d = rd_ptr_q;
    if (proc_fire) begin
      wr_ptr_d = wr_ptr_q + PtrW'(res_cnt);
      count_d  = count_d + CntW'(res_cnt);
    end
    if (pop) begin
      rd_ptr_d = rd_ptr_q + PtrW'(1);
      count_d  = count_d - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      sep_q      <= ResetSep;
      st_q       <= StClear;
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      count_q    <= '0;
    end else begin
      if (s_fire) begin
        in_valid_q <= 1'b1;
      end else if (proc_fire) begin
        in_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        sep_q <= cfg_wdata_i;
      end
      if (proc_fire) begin
        st_q <= st_d;
      end
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_fire) begin
      for (int i = 0; i < MaxRes; i++) begin
        if (ResCntW'(i) < res_cnt) begin
          mem[PtrW'(wr_ptr_q + PtrW'(i))] <= res[i];
        end
      end
    end
  end

  assign head            = mem[rd_ptr_q];
  assign m_axis_tvalid_o = (count_q != '0);
  assign m_axis_tdata_o  = {head.run_last, head.ch};
  assign m_axis_tlast_o  = head.string_end;
  assign m_axis_tuser_o  = head.err;

endmodule
`default_nettype wire

/* sv/u8mu7_checker.sv */
// Port checker for the modified UTF-7 encoder and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
module u8mu7_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid_i,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_i,
  input logic       m_axis_tlast_i,
  input logic       m_axis_tuser_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tready_i |=>
      m_axis_tvalid_i && $stable(m_axis_tdata_i) &&
      $stable(m_axis_tlast_i) && $stable(m_axis_tuser_i))
    else $error("stalled result request changed");

  a_err_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && m_axis_tuser_i |->
      m_axis_tlast_i && (m_axis_tdata_i == 8'h80))
    else $error("error result not a single closing nul");

  a_end_closes_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && m_axis_tlast_i |-> m_axis_tdata_i[7])
    else $error("string end without run_last");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid_i)
    else $error("result offered during reset");

endmodule

bind utf8_to_modified_utf7_encoder u8mu7_checker u_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o),
  .m_axis_tlast_i  (m_axis_tlast_o),
  .m_axis_tuser_i  (m_axis_tuser_o)
);
`default_nettype wire
